>>> rtl/core/itp_pkg.sv
// itp_pkg: shared types, codes and helpers for the infix to postfix converter
// no dependencies; imported by the interfaces and every module of the block
package itp_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int STACK_CAP   = (STACK_DEPTH > 32) ? 32 : STACK_DEPTH;
  localparam int IDX_W       = $clog2(STACK_CAP);
  localparam int CNT_W       = $clog2(STACK_CAP + 1);

  // field widths
  localparam int KIND_W  = 3;
  localparam int OP_W    = 4;
  localparam int VAL_W   = 32;
  localparam int OKIND_W = 2;
  localparam int ERR_W   = 2;
  localparam int ENTRY_W = 5;
  localparam int PREC_W  = 3;

  // input token kinds
  localparam logic [KIND_W-1:0] KIND_NUM = 3'd0;
  localparam logic [KIND_W-1:0] KIND_VAR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OP  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LB  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RB  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_END = 3'd5;

  // operator codes that set precedence and associativity
  localparam logic [OP_W-1:0] OP_SUB = 4'd1;
  localparam logic [OP_W-1:0] OP_DIV = 4'd3;
  localparam logic [OP_W-1:0] OP_POW = 4'd4;

  localparam logic [PREC_W-1:0] PREC_ADD  = 3'd2;
  localparam logic [PREC_W-1:0] PREC_MUL  = 3'd3;
  localparam logic [PREC_W-1:0] PREC_HIGH = 3'd4;

  // stack entry marking a left bracket
  localparam logic [ENTRY_W-1:0] ENTRY_LB = 5'd16;

  // result kinds
  localparam logic [OKIND_W-1:0] OUT_NUM  = 2'd0;
  localparam logic [OKIND_W-1:0] OUT_VAR  = 2'd1;
  localparam logic [OKIND_W-1:0] OUT_OP   = 2'd2;
  localparam logic [OKIND_W-1:0] OUT_NONE = 2'd3;

  // error codes
  localparam logic [ERR_W-1:0] ERR_OK  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RB  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_LB  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_OVF = 2'd3;

  typedef enum logic [2:0] {
    CMD_NUM,
    CMD_VAR,
    CMD_OP,
    CMD_LB,
    CMD_RB,
    CMD_END
  } cmd_kind_t;

  // classified token handed from front to back
  typedef struct packed {
    cmd_kind_t          kind;
    logic [OP_W-1:0]    op;
    logic [PREC_W-1:0]  prec;
    logic               left;
    logic [VAL_W-1:0]   value;
  } cmd_t;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } back_state_t;

  function automatic logic [PREC_W-1:0] prec_of(input logic [OP_W-1:0] op);
    logic [PREC_W-1:0] p;
    begin
      if (op <= OP_SUB) p = PREC_ADD;
      else if (op <= OP_DIV) p = PREC_MUL;
      else p = PREC_HIGH;
      return p;
    end
  endfunction

endpackage

>>> rtl/core/itp_token_if.sv
// itp_token_if: valid/ready channel carrying one infix token
// depends on itp_pkg for field widths
interface itp_token_if;
  import itp_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [OP_W-1:0]   op_code;
  logic [VAL_W-1:0]  number_value;

  modport source (output valid, kind, op_code, number_value, input ready);
  modport sink   (input valid, kind, op_code, number_value, output ready);
endinterface

>>> rtl/core/itp_result_if.sv
// itp_result_if: valid/ready channel carrying one postfix result
// depends on itp_pkg for field widths
interface itp_result_if;
  import itp_pkg::*;

  logic               valid;
  logic               ready;
  logic [OKIND_W-1:0] out_kind;
  logic [OP_W-1:0]    out_op_code;
  logic [VAL_W-1:0]   out_value;
  logic               last;
  logic [ERR_W-1:0]   error;

  modport source (output valid, out_kind, out_op_code, out_value, last, error, input ready);
  modport sink   (input valid, out_kind, out_op_code, out_value, last, error, output ready);
endinterface

>>> rtl/core/infix_to_postfix_converter.sv
// infix_to_postfix_converter: shunting yard converter, top level
// depends on itp_pkg, itp_token_if, itp_result_if, itp_front, itp_back
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+----------------------------------------------
//   tokens    | in  | valid / ready | kind, op_code, number_value
//   results   | out | valid / ready | out_kind, out_op_code, out_value, last, error
//
// a number or variable token passes through the back end as a command load and then an emit;
// an operator, right bracket or end token is loaded and then pops any stack entries it must;
// the pop sequencer reads one stack entry per cycle unless a stalled results channel holds it
// the front queue holds two commands, so tokens are still accepted while the back end pops, until it fills
// rst (synchronous) empties the queue and the stack; stack entries need no clearing
// a stalled results channel holds the output register and stops the pop sequencer once a popped operator waits
module infix_to_postfix_converter (
  input  logic         clk,
  input  logic         rst,
  itp_token_if.sink    tokens,
  itp_result_if.source results
);
  import itp_pkg::*;

  // classified command between front and back
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  // front: accept transactions, classify, queue
  itp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .tokens    (tokens),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // back: operator stack and result emission
  itp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_in    (cmd),
    .cmd_take  (cmd_take),
    .results   (results)
  );
endmodule

>>> rtl/core/itp_front.sv
// itp_front: accepts tokens, classifies them and queues commands (two entries)
// depends on itp_pkg and itp_token_if
module itp_front (
  input  logic           clk,
  input  logic           rst,
  itp_token_if.sink      tokens,
  output logic           cmd_valid,
  output itp_pkg::cmd_t  cmd,
  input  logic           cmd_take
);
  import itp_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  cmd_t cls;
  logic cls_ok;
  logic accept;
  logic push;
  logic pop;

  always_comb begin
    cls       = '0;
    cls.op    = tokens.op_code;
    cls.prec  = prec_of(tokens.op_code);
    cls.left  = (tokens.op_code != OP_POW);
    cls.value = tokens.number_value;
    cls_ok    = 1'b1;
    unique case (tokens.kind)
      KIND_NUM: cls.kind = CMD_NUM;
      KIND_VAR: cls.kind = CMD_VAR;
      KIND_OP:  cls.kind = CMD_OP;
      KIND_LB:  cls.kind = CMD_LB;
      KIND_RB:  cls.kind = CMD_RB;
      KIND_END: cls.kind = CMD_END;
      default: begin
        // unknown kinds are taken and dropped
        cls.kind = CMD_NUM;
        cls_ok   = 1'b0;
      end
    endcase
  end

  assign tokens.ready = (fill != 2'd2);
  assign accept       = tokens.valid && tokens.ready;
  assign push         = accept && cls_ok;
  assign cmd_valid    = (fill != 2'd0);
  assign cmd          = q[rd_ptr];
  assign pop          = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end
endmodule

>>> rtl/core/itp_back.sv
// itp_back: operator stack, pop sequencer and output register
// depends on itp_pkg and itp_result_if
module itp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  itp_pkg::cmd_t cmd_in,
  output logic          cmd_take,
  itp_result_if.source  results
);
  import itp_pkg::*;

  logic [ENTRY_W-1:0] stack [STACK_CAP];
  logic [CNT_W-1:0]   count, count_next;
  back_state_t        state, state_next;
  cmd_t               cmd, cmd_next;
  logic               pend_v, pend_v_next;
  logic [OP_W-1:0]    pend_op, pend_op_next;
  logic               lb_seen, lb_seen_next;

  logic               push_en;
  logic [ENTRY_W-1:0] push_data;

  logic               emit;
  logic [OKIND_W-1:0] e_kind;
  logic [OP_W-1:0]    e_op;
  logic [VAL_W-1:0]   e_val;
  logic               e_last;
  logic [ERR_W-1:0]   e_err;

  logic               out_valid;
  logic               slot_free;
  logic               has;
  logic               full;
  logic [CNT_W-1:0]   top_cnt;
  logic [ENTRY_W-1:0] top;
  logic               top_lb;
  logic [PREC_W-1:0]  top_prec;
  logic               pops;
  logic               can_pop;

  assign slot_free = !out_valid || results.ready;
  assign has       = (count != '0);
  assign full      = (count >= CNT_W'(STACK_CAP));
  assign top_cnt   = count - CNT_W'(1);
  assign top       = stack[top_cnt[IDX_W-1:0]];
  assign top_lb    = (top == ENTRY_LB);
  assign top_prec  = prec_of(top[OP_W-1:0]);
  assign pops      = has && !top_lb &&
                     ((top_prec > cmd.prec) || (cmd.left && (top_prec == cmd.prec)));
  // a pop may go ahead once the held result, if any, can leave
  assign can_pop   = !pend_v || slot_free;

  always_comb begin
    state_next   = state;
    count_next   = count;
    cmd_next     = cmd;
    pend_v_next  = pend_v;
    pend_op_next = pend_op;
    lb_seen_next = lb_seen;
    cmd_take     = 1'b0;
    push_en      = 1'b0;
    push_data    = ENTRY_LB;
    emit         = 1'b0;
    e_kind       = pend_v ? OUT_OP : OUT_NONE;
    e_op         = pend_v ? pend_op : '0;
    e_val        = '0;
    e_last       = 1'b0;
    e_err        = ERR_OK;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take     = 1'b1;
          cmd_next     = cmd_in;
          pend_v_next  = 1'b0;
          lb_seen_next = 1'b0;
          state_next   = S_RUN;
        end
      end
      S_RUN: begin
        unique case (cmd.kind)
          CMD_NUM, CMD_VAR: begin
            if (slot_free) begin
              emit       = 1'b1;
              e_kind     = (cmd.kind == CMD_NUM) ? OUT_NUM : OUT_VAR;
              e_op       = '0;
              e_val      = (cmd.kind == CMD_NUM) ? cmd.value : '0;
              e_last     = 1'b1;
              state_next = S_IDLE;
            end
          end
          CMD_OP: begin
            if (pops) begin
              if (can_pop) begin
                emit         = pend_v;
                pend_v_next  = 1'b1;
                pend_op_next = top[OP_W-1:0];
                count_next   = count - CNT_W'(1);
              end
            end else if (full) begin
              if (slot_free) begin
                emit       = 1'b1;
                e_last     = 1'b1;
                e_err      = ERR_OVF;
                state_next = S_IDLE;
              end
            end else if (can_pop) begin
              push_en    = 1'b1;
              push_data  = {1'b0, cmd.op};
              count_next = count + CNT_W'(1);
              emit       = pend_v;
              e_last     = 1'b1;
              state_next = S_IDLE;
            end
          end
          CMD_LB: begin
            if (full) begin
              if (slot_free) begin
                emit       = 1'b1;
                e_last     = 1'b1;
                e_err      = ERR_OVF;
                state_next = S_IDLE;
              end
            end else begin
              push_en    = 1'b1;
              push_data  = ENTRY_LB;
              count_next = count + CNT_W'(1);
              state_next = S_IDLE;
            end
          end
          CMD_RB: begin
            if (has) begin
              if (can_pop) begin
                count_next = count - CNT_W'(1);
                emit       = pend_v;
                if (top_lb) begin
                  // matching bracket found and discarded
                  e_last     = 1'b1;
                  state_next = S_IDLE;
                end else begin
                  pend_v_next  = 1'b1;
                  pend_op_next = top[OP_W-1:0];
                end
              end
            end else if (slot_free) begin
              emit       = 1'b1;
              e_last     = 1'b1;
              e_err      = ERR_RB;
              state_next = S_IDLE;
            end
          end
          CMD_END: begin
            if (has) begin
              if (top_lb) begin
                count_next   = count - CNT_W'(1);
                lb_seen_next = 1'b1;
              end else if (can_pop) begin
                emit         = pend_v;
                pend_v_next  = 1'b1;
                pend_op_next = top[OP_W-1:0];
                count_next   = count - CNT_W'(1);
              end
            end else if (slot_free) begin
              emit       = 1'b1;
              e_last     = 1'b1;
              e_err      = lb_seen ? ERR_LB : ERR_OK;
              state_next = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    pend_v  <= pend_v_next;
    pend_op <= pend_op_next;
    lb_seen <= lb_seen_next;
    if (push_en) begin
      stack[count[IDX_W-1:0]] <= push_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      results.out_kind    <= e_kind;
      results.out_op_code <= e_op;
      results.out_value   <= e_val;
      results.last        <= e_last;
      results.error       <= e_err;
    end
  end

  assign results.valid = out_valid;
endmodule
